/* sv/bsks_pkg.sv */
// ----------------------------------------------------------------------------
// bsks_pkg
// Shared types and constants for the bounded sorted key set.
// ----------------------------------------------------------------------------
`default_nettype none

package bsks_pkg;

	// fixed field widths of the channels
	localparam int OpcodeBits = 2;
	localparam int KeyWidth   = 64;
	localparam int IndexBits  = 3;
	localparam int StatusBits = 3;
	localparam int CountBits  = 4;
	localparam int CapBits    = 4;

	// defaults for the top-level parameters
	localparam int DepthDefault   = 8;
	localparam int KeyBitsDefault = 64;

	localparam logic [CapBits-1:0] CapacityReset = CapBits'(8);

	// opcodes; the two remaining codes both decode as a read
	localparam logic [OpcodeBits-1:0] OpAdd  = OpcodeBits'(0);
	localparam logic [OpcodeBits-1:0] OpDrop = OpcodeBits'(1);

	typedef enum logic [StatusBits-1:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_DROPPED  = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_READOK   = 3'd5,
		ST_RANGE    = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHUP_RD,
		S_SHUP_WR,
		S_SHDN_RD,
		S_SHDN_WR,
		S_READ_RD,
		S_READ_OUT
	} state_t;

endpackage

`default_nettype wire

/* sv/bsks_if.sv */
// ----------------------------------------------------------------------------
// bsks_cmd_if / bsks_res_if
// Valid/ready channels carrying commands into and results out of the set.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsks_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [bsks_pkg::OpcodeBits-1:0]    opcode;
	logic [bsks_pkg::KeyWidth-1:0]      key;
	logic [bsks_pkg::IndexBits-1:0]     index;

	modport source (output valid, output opcode, output key, output index, input ready);
	modport sink   (input valid, input opcode, input key, input index, output ready);
endinterface

interface bsks_res_if;
	logic                               valid;
	logic                               ready;
	logic [bsks_pkg::StatusBits-1:0]    status;
	logic [bsks_pkg::CountBits-1:0]     count;
	logic [bsks_pkg::KeyWidth-1:0]      entry;

	modport source (output valid, output status, output count, output entry, input ready);
	modport sink   (input valid, input status, input count, input entry, output ready);
endinterface

`default_nettype wire

/* sv/bounded_sorted_key_set.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_key_set
// Up to DEPTH distinct keys held in ascending unsigned order in a small RAM.
// ----------------------------------------------------------------------------
// One command per transfer, one result per command. A key RAM (one write,
// one registered read per cycle) and one key comparator are stepped by a
// sequencer, and cmd.ready is low while a command is in progress. A read in
// range fetches its entry and then returns it; a read out of range is refused
// at once, as is an add or drop refused at once (full, or drop on an empty
// set). Otherwise entries are scanned (the scan stops at the first entry not
// below the key); a duplicate or a missing key ends there, while an add or
// drop that goes ahead then shifts the entries behind that position. The RAM
// needs no clearing after reset: only entries below the count are ever used.
`default_nettype none

module bounded_sorted_key_set #(
	parameter int DEPTH    = bsks_pkg::DepthDefault,
	parameter int KEY_BITS = bsks_pkg::KeyBitsDefault
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bsks_pkg::CapBits-1:0]  cfg_wdata,
	bsks_cmd_if.sink                           cmd,
	bsks_res_if.source                         res
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > bsks_pkg::CapBits) ? CW : bsks_pkg::CapBits;

	bsks_pkg::state_t state_q, state_d;

	logic [bsks_pkg::CapBits-1:0]    capacity_q;
	logic [XW-1:0]                   held_q;
	logic [XW-1:0]                   ptr_q;
	logic [XW-1:0]                   pos_q;
	logic [bsks_pkg::OpcodeBits-1:0] op_q;
	logic [KEY_BITS-1:0]             key_q;

	logic                            out_valid_q;
	bsks_pkg::status_t               status_q;
	logic [bsks_pkg::CountBits-1:0]  count_q;
	logic [bsks_pkg::KeyWidth-1:0]   entry_q;

	logic [KEY_BITS-1:0] mem [DEPTH];
	logic [KEY_BITS-1:0] rdata_q;

	logic                cmd_xfer;
	logic                full;
	logic                idx_ok;
	logic                is_add_in;
	logic                is_drop_in;
	logic                is_add;
	logic                key_eq;
	logic                key_gt;
	logic                scan_last;
	logic [XW-1:0]       idx_x;

	// sequencer outputs
	logic                mem_we;
	logic [AW-1:0]       waddr;
	logic [KEY_BITS-1:0] wdata;
	logic [AW-1:0]       raddr;
	logic                done;
	bsks_pkg::status_t   done_status;
	logic                held_inc;
	logic                held_dec;
	logic [XW-1:0]       held_upd;

	assign cmd.ready = (state_q == bsks_pkg::S_IDLE) && (!out_valid_q || res.ready);
	assign cmd_xfer  = cmd.valid && cmd.ready;

	assign res.valid  = out_valid_q;
	assign res.status = status_q;
	assign res.count  = count_q;
	assign res.entry  = entry_q;

	assign full       = (held_q >= XW'(capacity_q)) || (held_q >= XW'(DEPTH));
	assign idx_x      = XW'(cmd.index);
	assign idx_ok     = idx_x < held_q;
	assign is_add_in  = cmd.opcode == bsks_pkg::OpAdd;
	assign is_drop_in = cmd.opcode == bsks_pkg::OpDrop;
	assign is_add     = op_q == bsks_pkg::OpAdd;
	assign key_eq     = rdata_q == key_q;
	assign key_gt     = rdata_q > key_q;
	assign scan_last  = (ptr_q + XW'(1)) == held_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsks_pkg::S_IDLE: begin
				if (cmd_xfer) begin
					priority if (is_add_in) begin
						if (full)
							state_d = bsks_pkg::S_IDLE;
						else if (held_q == '0)
							state_d = bsks_pkg::S_SHUP_RD;
						else
							state_d = bsks_pkg::S_SCAN_RD;
					end else if (is_drop_in) begin
						state_d = (held_q == '0) ? bsks_pkg::S_IDLE : bsks_pkg::S_SCAN_RD;
					end else begin
						state_d = idx_ok ? bsks_pkg::S_READ_RD : bsks_pkg::S_IDLE;
					end
				end
			end
			bsks_pkg::S_SCAN_RD:  state_d = bsks_pkg::S_SCAN_CMP;
			bsks_pkg::S_SCAN_CMP: begin
				priority if (key_eq)
					state_d = is_add ? bsks_pkg::S_IDLE : bsks_pkg::S_SHDN_RD;
				else if (key_gt || scan_last)
					state_d = is_add ? bsks_pkg::S_SHUP_RD : bsks_pkg::S_IDLE;
				else
					state_d = bsks_pkg::S_SCAN_RD;
			end
			bsks_pkg::S_SHUP_RD:
				state_d = (ptr_q == pos_q) ? bsks_pkg::S_IDLE : bsks_pkg::S_SHUP_WR;
			bsks_pkg::S_SHUP_WR:  state_d = bsks_pkg::S_SHUP_RD;
			bsks_pkg::S_SHDN_RD:
				state_d = ((ptr_q + XW'(1)) >= held_q) ? bsks_pkg::S_IDLE
				                                       : bsks_pkg::S_SHDN_WR;
			bsks_pkg::S_SHDN_WR:  state_d = bsks_pkg::S_SHDN_RD;
			bsks_pkg::S_READ_RD:  state_d = bsks_pkg::S_READ_OUT;
			bsks_pkg::S_READ_OUT: state_d = bsks_pkg::S_IDLE;
			default:              state_d = bsks_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_we      = 1'b0;
		waddr       = ptr_q[AW-1:0];
		wdata       = rdata_q;
		raddr       = ptr_q[AW-1:0];
		done        = 1'b0;
		done_status = bsks_pkg::ST_READOK;
		held_inc    = 1'b0;
		held_dec    = 1'b0;
		unique case (state_q)
			bsks_pkg::S_IDLE: begin
				raddr = idx_x[AW-1:0];
				if (cmd_xfer) begin
					priority if (is_add_in) begin
						if (full) begin
							done        = 1'b1;
							done_status = bsks_pkg::ST_FULL;
						end
					end else if (is_drop_in) begin
						if (held_q == '0) begin
							done        = 1'b1;
							done_status = bsks_pkg::ST_NOTFOUND;
						end
					end else begin
						if (!idx_ok) begin
							done        = 1'b1;
							done_status = bsks_pkg::ST_RANGE;
						end
					end
				end
			end
			bsks_pkg::S_SCAN_CMP: begin
				priority if (key_eq) begin
					if (is_add) begin
						done        = 1'b1;
						done_status = bsks_pkg::ST_DUP;
					end
				end else if (key_gt || scan_last) begin
					if (!is_add) begin
						done        = 1'b1;
						done_status = bsks_pkg::ST_NOTFOUND;
					end
				end
			end
			bsks_pkg::S_SHUP_RD: begin
				raddr = ptr_q[AW-1:0] - AW'(1);
				if (ptr_q == pos_q) begin
					mem_we      = 1'b1;
					waddr       = pos_q[AW-1:0];
					wdata       = key_q;
					done        = 1'b1;
					done_status = bsks_pkg::ST_ADDED;
					held_inc    = 1'b1;
				end
			end
			bsks_pkg::S_SHUP_WR: mem_we = 1'b1;
			bsks_pkg::S_SHDN_RD: begin
				raddr = ptr_q[AW-1:0] + AW'(1);
				if ((ptr_q + XW'(1)) >= held_q) begin
					done        = 1'b1;
					done_status = bsks_pkg::ST_DROPPED;
					held_dec    = 1'b1;
				end
			end
			bsks_pkg::S_SHDN_WR: mem_we = 1'b1;
			bsks_pkg::S_READ_OUT: begin
				done        = 1'b1;
				done_status = bsks_pkg::ST_READOK;
			end
			default: begin
			end
		endcase
	end

	assign held_upd = held_q + XW'(held_inc) - XW'(held_dec);

	// key RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsks_pkg::S_IDLE;
			capacity_q  <= bsks_pkg::CapacityReset;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				capacity_q <= cfg_wdata;
			held_q <= held_upd;
			if (done)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	// command and pointer registers; a read keeps its index in the pointer
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_q  <= cmd.opcode;
			key_q <= cmd.key[KEY_BITS-1:0];
			ptr_q <= (is_add_in || is_drop_in) ? '0 : idx_x;
			pos_q <= '0;
		end
		unique case (state_q)
			bsks_pkg::S_SCAN_CMP: begin
				priority if (key_eq) begin
					ptr_q <= ptr_q;
				end else if (key_gt) begin
					pos_q <= ptr_q;
					ptr_q <= held_q;
				end else if (scan_last) begin
					pos_q <= held_q;
					ptr_q <= held_q;
				end else begin
					ptr_q <= ptr_q + XW'(1);
				end
			end
			bsks_pkg::S_SHUP_WR: ptr_q <= ptr_q - XW'(1);
			bsks_pkg::S_SHDN_WR: ptr_q <= ptr_q + XW'(1);
			default: begin
			end
		endcase
		if (done) begin
			status_q <= done_status;
			count_q  <= bsks_pkg::CountBits'(held_upd);
			if (state_q == bsks_pkg::S_READ_OUT)
				entry_q <= bsks_pkg::KeyWidth'(rdata_q);
			else
				entry_q <= '0;
		end
	end

endmodule

`default_nettype wire

/* bench/bounded_sorted_key_set_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_sorted_key_set_tb
// Self-checking bench for the sorted key set. A shadow roster is updated at
// every command transfer and predicts status, count and entry for each
// reply. It runs directed corner cases, capacity changes, a long receiver
// hold, then random phases.
// ----------------------------------------------------------------------------

module bounded_sorted_key_set_tb;

	localparam int Depth    = bsks_pkg::DepthDefault;
	localparam int PoolSize = 10;

	// both remaining codes decode as a read
	localparam logic [bsks_pkg::OpcodeBits-1:0] OpRead     = bsks_pkg::OpcodeBits'(2);
	localparam logic [bsks_pkg::OpcodeBits-1:0] OpReadHigh = bsks_pkg::OpcodeBits'(3);

	localparam logic [bsks_pkg::KeyWidth-1:0] KeyAlice = 64'h414C_4943_4500_0000;
	localparam logic [bsks_pkg::KeyWidth-1:0] KeyAl    = 64'h414C_0000_0000_0000;
	localparam logic [bsks_pkg::KeyWidth-1:0] KeyBob   = 64'h424F_4200_0000_0000;
	localparam logic [bsks_pkg::KeyWidth-1:0] KeyZed   = 64'h5A45_4400_0000_0000;
	localparam logic [bsks_pkg::KeyWidth-1:0] KeyOnes  = '1;

	typedef struct packed {
		logic [bsks_pkg::OpcodeBits-1:0] opcode;
		logic [bsks_pkg::KeyWidth-1:0]   key;
		logic [bsks_pkg::IndexBits-1:0]  index;
	} cmd_t;

	typedef struct packed {
		bsks_pkg::status_t              status;
		logic [bsks_pkg::CountBits-1:0] count;
		logic [bsks_pkg::KeyWidth-1:0]  entry;
	} reply_t;

	bit                           clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [bsks_pkg::CapBits-1:0] cfg_wdata;

	bsks_cmd_if cmd_ch ();
	bsks_res_if res_ch ();

	bounded_sorted_key_set DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	always #4 clk = ~clk;

	// shadow roster
	logic [bsks_pkg::KeyWidth-1:0] roster_keys[$];
	int                            roster_cap = int'(bsks_pkg::CapacityReset);
	reply_t                        awaited_replies[$];

	int tx_gap_max   = 18;
	int rx_stall_max = 18;
	int rx_hold      = 0;
	int errors       = 0;
	int n_cmds       = 0;
	int n_replies    = 0;
	int status_seen[8];

	function automatic reply_t roster_reply(input cmd_t c);
		reply_t r;
		int     at;
		r.entry = '0;
		at = -1;
		foreach (roster_keys[i])
			if (roster_keys[i] == c.key)
				at = i;
		if (c.opcode == bsks_pkg::OpAdd) begin
			// full is checked before duplicate; capacity beyond Depth clips
			if (roster_keys.size() >= roster_cap || roster_keys.size() >= Depth) begin
				r.status = bsks_pkg::ST_FULL;
			end else if (at >= 0) begin
				r.status = bsks_pkg::ST_DUP;
			end else begin
				at = 0;
				while (at < roster_keys.size() && roster_keys[at] < c.key)
					at++;
				roster_keys.insert(at, c.key);
				r.status = bsks_pkg::ST_ADDED;
			end
		end else if (c.opcode == bsks_pkg::OpDrop) begin
			if (at < 0) begin
				r.status = bsks_pkg::ST_NOTFOUND;
			end else begin
				roster_keys.delete(at);
				r.status = bsks_pkg::ST_DROPPED;
			end
		end else if (int'(c.index) < roster_keys.size()) begin
			r.status = bsks_pkg::ST_READOK;
			r.entry  = roster_keys[c.index];
		end else begin
			r.status = bsks_pkg::ST_RANGE;
		end
		r.count = bsks_pkg::CountBits'(roster_keys.size());
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH %s", $realtime, what);
		errors++;
	endtask

	// Both channels observed at the falling edge, before the transfer edge.
	// Command first so a same-cycle reply still finds its expectation.
	always @(negedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				want = roster_reply('{cmd_ch.opcode, cmd_ch.key, cmd_ch.index});
				awaited_replies.insert(awaited_replies.size(), want);
				n_cmds++;
			end
			if (res_ch.valid && res_ch.ready) begin
				n_replies++;
				if (awaited_replies.size() == 0) begin
					report_mismatch($sformatf("reply with nothing outstanding: status %0d",
						res_ch.status));
				end else begin
					want = awaited_replies.pop_front();
					status_seen[int'(want.status)]++;
					if (res_ch.status !== want.status)
						report_mismatch($sformatf("reply %0d status: exp %s got %0d",
							n_replies, want.status.name(), res_ch.status));
					if (res_ch.count !== want.count)
						report_mismatch($sformatf("reply %0d count: exp %0d got %0d",
							n_replies, want.count, res_ch.count));
					if (res_ch.entry !== want.entry)
						report_mismatch($sformatf("reply %0d entry: exp %h got %h",
							n_replies, want.entry, res_ch.entry));
				end
			end
		end
	end

	// result sink: random stall per reply, plus an optional long hold
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			stall = $urandom_range(0, rx_stall_max);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(negedge clk); while (!(res_ch.valid && res_ch.ready));
			@(posedge clk);
		end
	end

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_item(input logic [bsks_pkg::OpcodeBits-1:0] op,
			input logic [bsks_pkg::KeyWidth-1:0] k,
			input logic [bsks_pkg::IndexBits-1:0] idx);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.key    <= k;
		cmd_ch.index  <= idx;
		do @(negedge clk); while (!cmd_ch.ready);
		@(posedge clk);
	endtask

	task automatic wait_drained;
		cmd_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input int cap);
		cfg_we    <= 1'b1;
		cfg_wdata <= bsks_pkg::CapBits'(cap);
		@(posedge clk);
		cfg_we    <= 1'b0;
		roster_cap = cap;
	endtask

	task automatic test_directed;
		send_item(OpRead, KeyOnes, 3'd0);        // read on empty set
		send_item(bsks_pkg::OpDrop, '0, 3'd0);   // drop on empty set
		send_item(bsks_pkg::OpAdd, KeyAlice, 3'd7);
		send_item(bsks_pkg::OpAdd, '0, 3'd0);    // new minimum
		send_item(bsks_pkg::OpAdd, KeyOnes, 3'd0); // new maximum
		send_item(bsks_pkg::OpAdd, KeyAlice, 3'd0); // duplicate
		send_item(bsks_pkg::OpAdd, 64'h8000_0000_0000_0000, 3'd0);
		send_item(bsks_pkg::OpAdd, KeyBob, 3'd0);
		send_item(bsks_pkg::OpAdd, 64'h1, 3'd0);
		send_item(bsks_pkg::OpAdd, KeyAl, 3'd0); // prefix of an existing name
		send_item(bsks_pkg::OpAdd, 64'h7FFF_FFFF_FFFF_FFFF, 3'd0);
		send_item(bsks_pkg::OpAdd, KeyZed, 3'd0); // full
		send_item(bsks_pkg::OpAdd, KeyAlice, 3'd0); // full wins over duplicate
		for (int i = 0; i < Depth; i++)
			send_item(i % 2 ? OpReadHigh : OpRead, KeyOnes, bsks_pkg::IndexBits'(i));
		send_item(bsks_pkg::OpDrop, KeyOnes, 3'd0); // drop last
		send_item(bsks_pkg::OpDrop, '0, 3'd0);      // drop first
		send_item(bsks_pkg::OpDrop, KeyBob, 3'd0);  // drop from the middle
		send_item(bsks_pkg::OpDrop, KeyBob, 3'd0);  // already gone
		send_item(OpRead, '0, 3'd5);                // just past the count
		send_item(OpReadHigh, '0, 3'd4);
	endtask

	task automatic test_capacity;
		wait_drained();
		set_capacity(0);
		send_item(bsks_pkg::OpAdd, KeyZed, 3'd0);
		send_item(bsks_pkg::OpDrop, KeyAlice, 3'd0);
		send_item(bsks_pkg::OpAdd, KeyAlice, 3'd0);
		send_item(OpRead, '0, 3'd0);
		wait_drained();
		set_capacity(2);                         // below the current count
		send_item(bsks_pkg::OpAdd, KeyZed, 3'd0);
		send_item(bsks_pkg::OpDrop, KeyAl, 3'd0);
		send_item(bsks_pkg::OpDrop, 64'h1, 3'd0);
		send_item(bsks_pkg::OpAdd, KeyZed, 3'd0);
		send_item(OpReadHigh, '0, 3'd1);
		wait_drained();
		set_capacity(15);                        // clipped to Depth
		for (int i = 0; i < Depth; i++)
			send_item(bsks_pkg::OpAdd, {$urandom, $urandom},
				bsks_pkg::IndexBits'($urandom_range(0, 7)));
		send_item(OpReadHigh, '0, 3'd7);
		send_item(bsks_pkg::OpAdd, 64'h8000_0000_0000_0000, 3'd0);
		wait_drained();
		set_capacity(8);
	endtask

	// receiver hold counted by the sink process; the sender keeps offering
	task automatic test_backpressure;
		wait_drained();
		tx_gap_max   = 0;
		rx_stall_max = 0;
		rx_hold      = 300;
		for (int i = 0; i < 30; i++)
			send_item(i % 3 == 0 ? bsks_pkg::OpAdd
				: (i % 3 == 1 ? OpRead : bsks_pkg::OpDrop),
				{$urandom, $urandom} & 64'hFF00_0000_0000_00FF, bsks_pkg::IndexBits'(i));
		wait_drained();
	endtask

	task automatic test_random;
		int                              caps[8] = '{8, 15, 5, 0, 9, 3, 1, 8};
		logic [bsks_pkg::KeyWidth-1:0]   pool[PoolSize];
		logic [bsks_pkg::KeyWidth-1:0]   k;
		logic [bsks_pkg::OpcodeBits-1:0] op;
		int                              len;
		int                              r;
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			set_capacity(caps[ph]);
			tx_gap_max   = (ph % 4 == 0 || ph % 4 == 2) ? 18 : 0;
			rx_stall_max = (ph % 4 == 0 || ph % 4 == 3) ? 18 : 0;
			// half packed names, half raw words
			for (int j = 0; j < PoolSize; j++) begin
				if (j % 2) begin
					pool[j] = {$urandom, $urandom};
				end else begin
					pool[j] = '0;
					len = $urandom_range(1, 8);
					for (int b = 0; b < len; b++)
						pool[j][63-8*b -: 8] = 8'($urandom_range(65, 122));
				end
			end
			for (int n = 0; n < 125; n++) begin
				r  = $urandom_range(0, 99);
				op = r < 45 ? bsks_pkg::OpAdd : (r < 75 ? bsks_pkg::OpDrop :
					($urandom_range(0, 1) ? OpRead : OpReadHigh));
				k  = $urandom_range(0, 99) < 85 ? pool[$urandom_range(0, PoolSize - 1)]
					: {$urandom, $urandom};
				send_item(op, k, bsks_pkg::IndexBits'($urandom_range(0, 7)));
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		cmd_ch.valid  <= 1'b0;
		cmd_ch.opcode <= '0;
		cmd_ch.key    <= '0;
		cmd_ch.index  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity();
		test_backpressure();
		test_random();

		wait_drained();
		repeat (40) @(posedge clk);
		if (awaited_replies.size() != 0)
			report_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));

		$display("covered %0d commands, %0d replies, capacities 0 to 15,", n_cmds, n_replies);
		$display("random idling on both sides and a long sink hold");
		$display("replies: added %0d full %0d dup %0d dropped %0d not found %0d read %0d range %0d",
			status_seen[bsks_pkg::ST_ADDED], status_seen[bsks_pkg::ST_FULL],
			status_seen[bsks_pkg::ST_DUP], status_seen[bsks_pkg::ST_DROPPED],
			status_seen[bsks_pkg::ST_NOTFOUND], status_seen[bsks_pkg::ST_READOK],
			status_seen[bsks_pkg::ST_RANGE]);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout after %0t", $realtime);
		$display("== FAIL ==");
		$finish;
	end

endmodule
